@@ rtl/core/slb_pkg.sv @@
// Shared types and constants for the savings list builder.
// Depends on nothing; every module of the block imports it.
package slb_pkg;

	localparam int MAX_CLIENTS = 32;
	localparam int CLIENT_W    = 5;
	localparam int CNT_W       = 6;
	localparam int COORD_W     = 16;
	localparam int POINT_W     = 2 * COORD_W;
	localparam int FRAC_BITS   = 8;
	localparam int ROOT_STEPS  = FRAC_BITS + 17;
	localparam int STEP_W      = 5;
	localparam int DIST_W      = 25;
	localparam int SAV_W       = 26;
	localparam int RANK_W      = 9;
	localparam int PCNT_W      = 10;
	localparam int PAIR_SLOTS  = (MAX_CLIENTS - 1) * (MAX_CLIENTS - 2) / 2;

	// Opcodes of an input beat.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	// One entry of the sorted savings list.
	typedef struct packed {
		logic [CLIENT_W-1:0] a;
		logic [CLIENT_W-1:0] b;
		logic [SAV_W-1:0]    sav;
	} entry_t;

endpackage

@@ rtl/core/slb_dist.sv @@
// Euclidean distance unit: squares in registered stages, then a bit-serial root.
// Depends on slb_pkg.
module slb_dist import slb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [POINT_W-1:0] pa,
	input  logic [POINT_W-1:0] pb,
	output logic               done,
	output logic [DIST_W-1:0]  distance
);

	typedef enum logic [2:0] {D_IDLE, D_MUL, D_SUM, D_ITER, D_DONE} dstate_t;

	dstate_t                 state_q;
	logic [COORD_W-1:0]      ax_q, ay_q;
	logic [2*COORD_W-1:0]    sqx_q, sqy_q;
	logic [2*COORD_W+1:0]    s_q;
	logic [DIST_W-1:0]       root_q;
	logic [DIST_W+2:0]       rem_q;
	logic [STEP_W-1:0]       step_q;

	logic signed [COORD_W:0] dx, dy;
	logic [COORD_W:0]        ndx, ndy;
	logic [DIST_W+2:0]       rem_n, trial;

	// Coordinate differences and their magnitudes.
	always_comb begin
		dx  = $signed({pb[POINT_W-1], pb[POINT_W-1:COORD_W]}) -
		      $signed({pa[POINT_W-1], pa[POINT_W-1:COORD_W]});
		dy  = $signed({pb[COORD_W-1], pb[COORD_W-1:0]}) -
		      $signed({pa[COORD_W-1], pa[COORD_W-1:0]});
		ndx = -dx;
		ndy = -dy;
	end

	// One root digit per step: bring down the next pair and try to subtract.
	always_comb begin
		rem_n = {rem_q[DIST_W:0], s_q[2*COORD_W+1:2*COORD_W]};
		trial = {1'b0, root_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			ax_q    <= '0;
			ay_q    <= '0;
			sqx_q   <= '0;
			sqy_q   <= '0;
			s_q     <= '0;
			root_q  <= '0;
			rem_q   <= '0;
			step_q  <= '0;
		end else begin
			case (state_q)
				D_IDLE: begin
					if (start) begin
						ax_q    <= dx[COORD_W] ? ndx[COORD_W-1:0] : dx[COORD_W-1:0];
						ay_q    <= dy[COORD_W] ? ndy[COORD_W-1:0] : dy[COORD_W-1:0];
						state_q <= D_MUL;
					end
				end
				D_MUL: begin
					sqx_q   <= ax_q * ax_q;
					sqy_q   <= ay_q * ay_q;
					state_q <= D_SUM;
				end
				D_SUM: begin
					s_q     <= {2'b00, sqx_q} + {2'b00, sqy_q};
					root_q  <= '0;
					rem_q   <= '0;
					step_q  <= '0;
					state_q <= D_ITER;
				end
				D_ITER: begin
					if (rem_n >= trial) begin
						rem_q  <= rem_n - trial;
						root_q <= {root_q[DIST_W-2:0], 1'b1};
					end else begin
						rem_q  <= rem_n;
						root_q <= {root_q[DIST_W-2:0], 1'b0};
					end
					s_q    <= {s_q[2*COORD_W-1:0], 2'b00};
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(ROOT_STEPS - 1)) begin
						state_q <= D_DONE;
					end
				end
				D_DONE: begin
					state_q <= D_IDLE;
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	assign done     = (state_q == D_DONE);
	assign distance = root_q;

endmodule

@@ rtl/core/savings_list_builder_core.sv @@
// Top level of the savings list builder: point, distance and sorted list memories
// and the build sequencer. Depends on slb_pkg and slb_dist.
//
// Usage: one input channel (in_valid/in_ready) carries load beats (op 0) and read
// beats (op 1); one output channel (out_valid/out_ready) carries one result beat
// per read. A load writes one point into the point memory. A load marked
// last_client starts a build: n distance computations to the depot, then for
// every pair of clients other than client 0 (the depot) a distance computation
// and an insertion into the sorted list memory. The shared root unit computes
// each distance's 25 root digits one per cycle. Each insertion walks up from the
// list tail, moving each entry with a smaller saving down one slot, and writes
// the new entry into the freed slot. in_ready stays low until the build ends.
// A read result passes from the list memory's read register through the holding
// stage into the output register. A result that waits for out_ready sits in the
// output register while one more read completes into the holding stage; further
// beats then wait. After reset no clients are loaded and the list is empty, so
// reads return rank_valid low with zero fields. No clearing pass is needed.
module savings_list_builder_core import slb_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                op,
	input  logic [COORD_W-1:0]  x_coord,
	input  logic [COORD_W-1:0]  y_coord,
	input  logic                last_client,
	input  logic [RANK_W-1:0]   rank,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [CLIENT_W-1:0] client_a,
	output logic [CLIENT_W-1:0] client_b,
	output logic [SAV_W-1:0]    saving_value,
	output logic                rank_valid
);

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_DRD, S_DLAT, S_DWAIT, S_PI, S_PILAT,
		S_PJ, S_PJLAT, S_PJW, S_INS, S_INSC
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    cnt_q, n_q, i_q, j_q;
	logic [PCNT_W-1:0]   k_q, pair_cnt_q;
	logic [POINT_W-1:0]  p0_q, ci_q;
	logic [DIST_W-1:0]   ddi_q, ddj_q;
	entry_t              ne_q;
	logic                rank_ok_q;
	logic                valid_s1;
	entry_t              ent_s1;
	logic                rv_s1;
	logic                out_valid_q;
	entry_t              out_q;
	logic                rv_q;

	logic [POINT_W-1:0]  pm [MAX_CLIENTS];
	logic [DIST_W-1:0]   dm [MAX_CLIENTS];
	entry_t              sm [2**RANK_W];
	logic [POINT_W-1:0]  pm_rdata;
	logic [DIST_W-1:0]   dm_rdata;
	entry_t              sm_rdata;
	logic [CLIENT_W-1:0] pm_raddr;
	logic [RANK_W-1:0]   sm_raddr, sm_waddr;
	logic                sm_we;
	entry_t              sm_wdata;
	logic                pm_we;

	logic                in_acc;
	logic                dist_start, dist_done;
	logic [POINT_W-1:0]  dist_pa;
	logic [DIST_W-1:0]   dist_val;
	logic [PCNT_W-1:0]   k_m1;
	logic [SAV_W-1:0]    sum, dist_ext, sav;

	assign in_acc = in_valid && in_ready;
	assign pm_we  = in_acc && (op == OP_LOAD) && (cnt_q < CNT_W'(MAX_CLIENTS));
	assign k_m1   = k_q - PCNT_W'(1);

	// Memory addresses, list writes and the distance unit hookup.
	always_comb begin
		pm_raddr   = (state_q == S_PJ) ? j_q[CLIENT_W-1:0] : i_q[CLIENT_W-1:0];
		sm_raddr   = (state_q == S_IDLE) ? rank : k_m1[RANK_W-1:0];
		sm_waddr   = k_q[RANK_W-1:0];
		sm_we      = 1'b0;
		sm_wdata   = ne_q;
		if (state_q == S_INS && k_q == '0) begin
			sm_we = 1'b1;
		end
		if (state_q == S_INSC) begin
			sm_we = 1'b1;
			if (sm_rdata.sav < ne_q.sav) begin
				sm_wdata = sm_rdata;
			end
		end
		dist_start = (state_q == S_DLAT) || (state_q == S_PJLAT);
		dist_pa    = (state_q == S_DLAT) ? p0_q : ci_q;
	end

	// Saving of the current pair, clamped at zero.
	always_comb begin
		sum      = {1'b0, ddi_q} + {1'b0, ddj_q};
		dist_ext = {1'b0, dist_val};
		sav      = (sum > dist_ext) ? (sum - dist_ext) : '0;
	end

	// Point memory.
	always_ff @(posedge clk) begin
		if (pm_we) begin
			pm[cnt_q[CLIENT_W-1:0]] <= {x_coord, y_coord};
		end
		pm_rdata <= pm[pm_raddr];
	end

	// Depot distance memory.
	always_ff @(posedge clk) begin
		if (state_q == S_DWAIT && dist_done) begin
			dm[i_q[CLIENT_W-1:0]] <= dist_val;
		end
		dm_rdata <= dm[pm_raddr];
	end

	// Sorted savings memory.
	always_ff @(posedge clk) begin
		if (sm_we) begin
			sm[sm_waddr] <= sm_wdata;
		end
		sm_rdata <= sm[sm_raddr];
	end

	slb_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dist_start),
		.pa       (dist_pa),
		.pb       (pm_rdata),
		.done     (dist_done),
		.distance (dist_val)
	);

	// Sequencer, holding stage and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			n_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			pair_cnt_q  <= '0;
			p0_q        <= '0;
			ci_q        <= '0;
			ddi_q       <= '0;
			ddj_q       <= '0;
			ne_q        <= '0;
			rank_ok_q   <= 1'b0;
			valid_s1    <= 1'b0;
			ent_s1      <= '0;
			rv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			rv_q        <= 1'b0;
		end else begin
			if (valid_s1 && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
				out_q       <= ent_s1;
				rv_q        <= rv_s1;
				valid_s1    <= 1'b0;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_acc && op == OP_READ) begin
						rank_ok_q <= ({1'b0, rank} < pair_cnt_q);
						state_q   <= S_RD;
					end else if (in_acc) begin
						if (pm_we && cnt_q == '0) begin
							p0_q <= {x_coord, y_coord};
						end
						if (last_client) begin
							n_q        <= pm_we ? cnt_q + CNT_W'(1) : cnt_q;
							cnt_q      <= '0;
							i_q        <= '0;
							pair_cnt_q <= '0;
							state_q    <= S_DRD;
						end else if (pm_we) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
				end
				S_RD: begin
					valid_s1 <= 1'b1;
					ent_s1   <= rank_ok_q ? sm_rdata : '0;
					rv_s1    <= rank_ok_q;
					state_q  <= S_IDLE;
				end
				S_DRD: begin
					if (i_q == n_q) begin
						i_q     <= CNT_W'(1);
						state_q <= S_PI;
					end else begin
						state_q <= S_DLAT;
					end
				end
				S_DLAT: begin
					state_q <= S_DWAIT;
				end
				S_DWAIT: begin
					if (dist_done) begin
						i_q     <= i_q + CNT_W'(1);
						state_q <= S_DRD;
					end
				end
				S_PI: begin
					if (i_q + CNT_W'(1) >= n_q) begin
						state_q <= S_IDLE;
					end else begin
						j_q     <= i_q + CNT_W'(1);
						state_q <= S_PILAT;
					end
				end
				S_PILAT: begin
					ci_q    <= pm_rdata;
					ddi_q   <= dm_rdata;
					state_q <= S_PJ;
				end
				S_PJ: begin
					if (j_q == n_q) begin
						i_q     <= i_q + CNT_W'(1);
						state_q <= S_PI;
					end else begin
						state_q <= S_PJLAT;
					end
				end
				S_PJLAT: begin
					ddj_q   <= dm_rdata;
					state_q <= S_PJW;
				end
				S_PJW: begin
					if (dist_done) begin
						ne_q.a   <= i_q[CLIENT_W-1:0];
						ne_q.b   <= j_q[CLIENT_W-1:0];
						ne_q.sav <= sav;
						k_q      <= pair_cnt_q;
						state_q  <= S_INS;
					end
				end
				S_INS: begin
					if (k_q == '0) begin
						pair_cnt_q <= pair_cnt_q + PCNT_W'(1);
						j_q        <= j_q + CNT_W'(1);
						state_q    <= S_PJ;
					end else begin
						state_q <= S_INSC;
					end
				end
				S_INSC: begin
					if (sm_rdata.sav < ne_q.sav) begin
						k_q     <= k_m1;
						state_q <= S_INS;
					end else begin
						pair_cnt_q <= pair_cnt_q + PCNT_W'(1);
						j_q        <= j_q + CNT_W'(1);
						state_q    <= S_PJ;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready     = (state_q == S_IDLE) && !valid_s1;
	assign out_valid    = out_valid_q;
	assign client_a     = out_q.a;
	assign client_b     = out_q.b;
	assign saving_value = out_q.sav;
	assign rank_valid   = rv_q;

	// The list never grows past the number of pair slots.
	a_pair_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pair_cnt_q <= PCNT_W'(PAIR_SLOTS))
		else $error("pair count exceeds the list size");

	// The root unit finishes only while the sequencer waits for it.
	a_dist_wait: assert property (@(posedge clk) disable iff (!arst_n)
		dist_done |-> (state_q == S_DWAIT || state_q == S_PJW))
		else $error("distance finished with no one waiting");

	// A read completes only into an empty holding stage.
	a_s1_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |-> !valid_s1)
		else $error("read result would overwrite the holding stage");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for savings_list_builder_core: loads client sets, reads the
// sorted savings list back and checks every result beat. Depends on slb_pkg and the RTL.
module tb_top;
	import slb_pkg::*;

	typedef struct {
		logic [CLIENT_W-1:0] a;
		logic [CLIENT_W-1:0] b;
		logic [SAV_W-1:0]    sav;
		logic                hit;
	} saving_beat_t;

	localparam int STALL_LIMIT = 1200000;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic                op;
	logic [COORD_W-1:0]  x_coord;
	logic [COORD_W-1:0]  y_coord;
	logic                last_client;
	logic [RANK_W-1:0]   rank;
	logic                out_valid;
	logic                out_ready;
	logic [CLIENT_W-1:0] client_a;
	logic [CLIENT_W-1:0] client_b;
	logic [SAV_W-1:0]    saving_value;
	logic                rank_valid;

	// Predictor state.
	logic [POINT_W-1:0]  pts [MAX_CLIENTS];
	int unsigned         loaded_cnt;
	logic [DIST_W-1:0]   depot_dist [MAX_CLIENTS];
	saving_beat_t        sorted_list [PAIR_SLOTS];
	int unsigned         list_len;
	saving_beat_t        pending_reads [$];

	int  errors;
	int  burst_left;
	bit  no_gaps;
	bit  hold_req;
	int  hold_len;
	int  idle_cycles;

	savings_list_builder_core u_top (.*);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Fixed-point square root, one result bit per step.
	function automatic logic [DIST_W-1:0] fixed_root(logic [63:0] s);
		logic [63:0] root;
		logic [63:0] rem;
		logic [63:0] trial;
		logic [63:0] digits;
		root = 0;
		rem  = 0;
		for (int p = ROOT_STEPS - 1; p >= 0; p--) begin
			digits = (p >= FRAC_BITS) ? ((s >> (2 * (p - FRAC_BITS))) & 64'd3) : 64'd0;
			rem = (rem << 2) | digits;
			trial = (root << 2) | 64'd1;
			if (rem >= trial) begin
				rem  = rem - trial;
				root = (root << 1) | 64'd1;
			end else begin
				root = root << 1;
			end
		end
		return root[DIST_W-1:0];
	endfunction

	function automatic logic [DIST_W-1:0] point_dist(logic [POINT_W-1:0] p,
			logic [POINT_W-1:0] q);
		longint dx;
		longint dy;
		dx = longint'($signed(q[31:16])) - longint'($signed(p[31:16]));
		dy = longint'($signed(q[15:0])) - longint'($signed(p[15:0]));
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		return fixed_root(dx * dx + dy * dy);
	endfunction

	// Rebuild the sorted savings list from the loaded set.
	task automatic build_savings(int unsigned n);
		logic [63:0] sum;
		logic [63:0] dij;
		int k;
		list_len = 0;
		for (int i = 0; i < n; i++) depot_dist[i] = point_dist(pts[0], pts[i]);
		for (int i = 1; i < n; i++) begin
			for (int j = i + 1; j < n; j++) begin
				dij = point_dist(pts[i], pts[j]);
				sum = depot_dist[i] + depot_dist[j];
				sum = (sum > dij) ? sum - dij : 64'd0;
				if (sum > 64'h3FFFFFF) sum = 64'h3FFFFFF;
				k = list_len;
				while (k > 0 && sorted_list[k-1].sav < sum) begin
					sorted_list[k] = sorted_list[k-1];
					k--;
				end
				sorted_list[k].a   = CLIENT_W'(i);
				sorted_list[k].b   = CLIENT_W'(j);
				sorted_list[k].sav = sum[SAV_W-1:0];
				sorted_list[k].hit = 1'b1;
				list_len++;
			end
		end
	endtask

	// Update the predictor for one accepted input beat.
	task automatic predict_beat(logic b_op, logic [15:0] bx, logic [15:0] by,
			logic b_last, logic [RANK_W-1:0] b_rank);
		saving_beat_t res;
		if (b_op == OP_LOAD) begin
			if (loaded_cnt < MAX_CLIENTS) begin
				pts[loaded_cnt] = {bx, by};
				loaded_cnt++;
			end
			if (b_last) begin
				build_savings(loaded_cnt);
				loaded_cnt = 0;
			end
		end else begin
			if (b_rank < list_len) begin
				res = sorted_list[b_rank];
			end else begin
				res = '{a: '0, b: '0, sav: '0, hit: 1'b0};
			end
			pending_reads.push_back(res);
		end
	endtask

	// Send one beat: bursts with random gaps, valid held until accepted.
	task automatic send_beat(logic b_op, logic [15:0] bx, logic [15:0] by,
			logic b_last, logic [RANK_W-1:0] b_rank);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = no_gaps ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid    <= 1'b1;
		op          <= b_op;
		x_coord     <= bx;
		y_coord     <= by;
		last_client <= b_last;
		rank        <= b_rank;
		do @(posedge clk); while (!in_ready);
		predict_beat(b_op, bx, by, b_last, b_rank);
	endtask

	task automatic load_point(logic [15:0] bx, logic [15:0] by, logic b_last);
		send_beat(OP_LOAD, bx, by, b_last, 9'($urandom));
	endtask

	task automatic read_rank(logic [RANK_W-1:0] r, logic b_last = 1'b0);
		send_beat(OP_READ, 16'($urandom), 16'($urandom), b_last, r);
	endtask

	// Random readback of the current list, mostly at valid ranks.
	task automatic read_back(int cnt);
		for (int i = 0; i < cnt; i++) begin
			if (list_len > 0 && $urandom_range(0, 9) < 8)
				read_rank(RANK_W'($urandom_range(0, list_len - 1)), 1'($urandom));
			else
				read_rank(9'($urandom), 1'($urandom));
		end
	endtask

	task automatic report(string what, longint got, longint exp);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $time);
		errors++;
	endtask

	// Result checker.
	always @(posedge clk) begin
		saving_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_reads.size() == 0) begin
				report("unexpected result beat", 0, 0);
			end else begin
				want = pending_reads.pop_front();
				if (client_a !== want.a) report("client_a", client_a, want.a);
				if (client_b !== want.b) report("client_b", client_b, want.b);
				if (saving_value !== want.sav) report("saving_value", saving_value, want.sav);
				if (rank_valid !== want.hit) report("rank_valid", rank_valid, want.hit);
			end
		end
	end

	// Receiver: stall pattern changes every stretch; long hold-off on request.
	initial begin
		int mode;
		int span;
		int hold_cnt;
		out_ready = 1'b0;
		hold_cnt = 0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 200);
			repeat (span) begin
				@(negedge clk);
				if (hold_req) begin
					hold_cnt = hold_len;
					hold_req = 1'b0;
				end
				if (hold_cnt > 0) begin
					hold_cnt--;
					out_ready <= 1'b0;
				end else begin
					case (mode)
						0: out_ready <= 1'b1;
						1: out_ready <= 1'($urandom);
						2: out_ready <= ($urandom_range(0, 7) != 0);
						default: out_ready <= ($urandom_range(0, 7) == 0);
					endcase
				end
			end
		end
	end

	// Watchdog on cycles without any accepted beat.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic logic [15:0] rand_coord(bit wide);
		return wide ? 16'($urandom) : 16'($signed($urandom_range(0, 400)) - 200);
	endfunction

	task automatic test_read_before_build();
		read_rank(9'd0);
		read_rank(9'd511, 1'b1);
	endtask

	// Sets of one and two clients give an empty list.
	task automatic test_tiny_sets();
		load_point(16'd5, 16'd5, 1'b1);
		read_rank(9'd0);
		load_point(16'd0, 16'd0, 1'b0);
		load_point(16'd9, 16'hFFF0, 1'b1);
		read_rank(9'd0);
	endtask

	// Coordinate extremes, and collinear points, some of whose pairs give zero savings.
	task automatic test_extremes();
		load_point(16'h8000, 16'h8000, 1'b0);
		load_point(16'h7FFF, 16'h7FFF, 1'b0);
		load_point(16'h7FFF, 16'h8000, 1'b0);
		load_point(16'h8000, 16'h7FFF, 1'b0);
		load_point(16'h0000, 16'hFFFF, 1'b1);
		for (int r = 0; r < 7; r++) read_rank(RANK_W'(r));
		read_rank(9'd10);
		load_point(16'd0, 16'd0, 1'b0);
		load_point(16'd10, 16'd0, 1'b0);
		load_point(16'hFFF6, 16'd0, 1'b0);
		load_point(16'd20, 16'd0, 1'b1);
		for (int r = 0; r < 4; r++) read_rank(RANK_W'(r));
	endtask

	// Overfull set: the extra point is dropped but its last mark still builds.
	task automatic test_store_full(bit wide);
		for (int i = 0; i <= MAX_CLIENTS; i++)
			load_point(rand_coord(wide), rand_coord(wide), i == MAX_CLIENTS);
		read_rank(9'd0);
		read_rank(RANK_W'(PAIR_SLOTS - 1));
		read_rank(RANK_W'(PAIR_SLOTS));
		read_rank(9'd511);
		read_back(20);
	endtask

	// The receiver holds off while reads keep coming, so the block backs up.
	task automatic test_backpressure();
		no_gaps = 1'b1;
		hold_len = 400;
		hold_req = 1'b1;
		read_back(30);
		no_gaps = 1'b0;
	endtask

	// Random sets, each followed by reads; counts every beat sent.
	task automatic test_random_sets(int beats);
		int sent;
		int n;
		int m;
		bit wide;
		sent = 0;
		while (sent < beats) begin
			no_gaps = ($urandom_range(0, 4) == 0);
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
			wide = 1'($urandom);
			for (int i = 0; i < n; i++) begin
				if (i > 0 && $urandom_range(0, 9) == 0)
					load_point(pts[0][31:16], pts[0][15:0], i == n - 1);
				else
					load_point(rand_coord(wide), rand_coord(wide), i == n - 1);
			end
			m = n + $urandom_range(4, 12);
			read_back(m);
			sent += n + m;
		end
		no_gaps = 1'b0;
	endtask

	// Main sequence.
	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		op          = OP_LOAD;
		x_coord     = '0;
		y_coord     = '0;
		last_client = 1'b0;
		rank        = '0;
		loaded_cnt  = 0;
		list_len    = 0;
		errors      = 0;
		burst_left  = 0;
		no_gaps     = 1'b0;
		hold_req    = 1'b0;
		hold_len    = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_read_before_build();
		test_tiny_sets();
		test_extremes();
		test_store_full(1'b1);
		test_backpressure();
		test_random_sets(830);
		test_store_full(1'b0);

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_reads.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
